// File: hw/rtl/rbdc_pkg.sv
`timescale 1ns / 1ps

package rbdc_pkg;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_DONE  = 2'd1,
		CMD_FETCH = 2'd2
	} rbdc_cmd_e;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] byte_value;
		logic       last_of_message;
		logic [8:0] fetch_index;
	} rbdc_in_t;

	typedef struct packed {
		logic       byte_dropped;
		logic       chunk_started;
		logic [8:0] chunk_start_index;
		logic [5:0] chunk_length;
		logic [7:0] fetched_byte;
	} rbdc_out_t;

	// request from the pointer logic to the byte store: write strobe, write data and fetch flag
	typedef struct packed {
		logic       fetch;
		logic       write;
		logic [7:0] wdata;
	} rbdc_mem_req_t;

endpackage

// File: hw/rtl/ring_buffer_dma_chunker_top.sv
`timescale 1ns / 1ps

// channel   handshake                     payload
// input     item_valid / item_ready       item   (rbdc_in_t: command, byte, last, fetch index)
// output    result_valid / result_ready   result (rbdc_out_t: drop, chunk start, fetched byte)
//
// One result word per input word, in the cycle after acceptance; throughput one word per
// cycle while result_ready stays high. The result register sets the rate: a new word is
// taken only when the register is empty or is being drained in the same cycle.
// Pushes and fetches use separate ports of the byte store; fetched data comes from its
// read register. Reset clears the pointers and the result valid flag; the byte store is
// not cleared. A stalled result holds the input side stalled too.

module ring_buffer_dma_chunker_top #(
	parameter int DEPTH     = 512,
	parameter int MAX_CHUNK = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  rbdc_pkg::rbdc_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output rbdc_pkg::rbdc_out_t result
);

	import rbdc_pkg::*;

	localparam int AW = $clog2(DEPTH);

	rbdc_mem_req_t mem_req;
	rbdc_out_t     res, res_q;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;
	logic          accept, valid_q, fetch_q;

	assign item_ready = !valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	rbdc_ctrl #(
		.DEPTH     (DEPTH),
		.MAX_CHUNK (MAX_CHUNK)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.mem_req (mem_req),
		.waddr   (waddr),
		.raddr   (raddr),
		.res     (res)
	);

	rbdc_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.write),
		.waddr (waddr),
		.wdata (mem_req.wdata),
		.re    (accept && mem_req.fetch),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item_ready) begin
			valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q   <= res;
			fetch_q <= mem_req.fetch;
		end
	end

	// read data stays put while the word waits: no read is issued without acceptance
	always_comb begin
		result              = res_q;
		result.fetched_byte = fetch_q ? rdata : '0;
	end

	assign result_valid = valid_q;

endmodule

// File: hw/rtl/rbdc_ram.sv
`timescale 1ns / 1ps

module rbdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/rbdc_ctrl.sv
`timescale 1ns / 1ps

module rbdc_ctrl #(
	parameter int DEPTH     = 512,
	parameter int MAX_CHUNK = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  rbdc_pkg::rbdc_in_t       item,
	output rbdc_pkg::rbdc_mem_req_t  mem_req,
	output logic [$clog2(DEPTH)-1:0] waddr,
	output logic [$clog2(DEPTH)-1:0] raddr,
	output rbdc_pkg::rbdc_out_t      res
);

	import rbdc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(MAX_CHUNK + 1);
	localparam int SW = ((AW > LW) ? AW : LW) + 1;

	logic [AW-1:0] wr_pos_q, send_pos_q;
	logic [LW-1:0] in_flight_q;

	logic [AW-1:0] wr_next, wr_after, wr_pos_n, send_pos_n;
	logic [LW-1:0] in_flight_n;
	logic [SW-1:0] done_sum;
	logic [AW:0]   span_end, span;
	logic [LW-1:0] len;
	logic          is_push, is_done, full, attempt, start;

	assign is_push = (item.command == CMD_PUSH);
	assign is_done = (item.command == CMD_DONE);

	always_comb begin
		wr_next  = (wr_pos_q == AW'(DEPTH - 1)) ? '0 : wr_pos_q + 1'b1;
		wr_after = (wr_next == AW'(DEPTH - 1)) ? '0 : wr_next + 1'b1;
		full     = (wr_next == send_pos_q);
		done_sum = SW'(send_pos_q) + SW'(in_flight_q);

		wr_pos_n    = wr_pos_q;
		send_pos_n  = send_pos_q;
		in_flight_n = in_flight_q;
		attempt     = 1'b0;

		if (is_push && !full) begin
			wr_pos_n = wr_next;
			attempt  = item.last_of_message || (wr_next == '0) || (wr_after == send_pos_q);
		end else if (is_done) begin
			send_pos_n  = (32'(done_sum) >= DEPTH) ? '0 : AW'(done_sum);
			in_flight_n = '0;
			attempt     = 1'b1;
		end

		// chunk runs to the write position, or to the ring end when data wraps, capped at MAX_CHUNK
		span_end = (wr_pos_n > send_pos_n) ? {1'b0, wr_pos_n} : (AW + 1)'(DEPTH);
		span     = span_end - {1'b0, send_pos_n};
		len      = (32'(span) > MAX_CHUNK) ? LW'(MAX_CHUNK) : LW'(span);
		start    = attempt && (in_flight_n == '0) && (wr_pos_n != send_pos_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q    <= '0;
			send_pos_q  <= '0;
			in_flight_q <= '0;
		end else if (accept) begin
			wr_pos_q    <= wr_pos_n;
			send_pos_q  <= send_pos_n;
			in_flight_q <= start ? len : in_flight_n;
		end
	end

	assign mem_req.write = accept && is_push && !full;
	assign mem_req.wdata = item.byte_value;
	assign mem_req.fetch = (item.command == CMD_FETCH) && (32'(item.fetch_index) < DEPTH);
	assign waddr         = wr_pos_q;
	assign raddr         = AW'(item.fetch_index);

	always_comb begin
		res                   = '0;
		res.byte_dropped      = is_push && full;
		res.chunk_started     = start;
		res.chunk_start_index = start ? 9'(send_pos_n) : '0;
		res.chunk_length      = start ? 6'(len) : '0;
	end

endmodule

// File: hw/rtl/rbdc_checker.sv
`timescale 1ns / 1ps

module rbdc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input rbdc_pkg::rbdc_in_t  item,
	input logic                result_valid,
	input logic                result_ready,
	input rbdc_pkg::rbdc_out_t result
);

	import rbdc_pkg::*;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word withdrawn while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result word changed while stalled");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted word produced no result");

	a_idle_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.chunk_started |->
			result.chunk_start_index == '0 && result.chunk_length == '0)
		else $error("chunk fields set without a chunk start");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_dropped |->
			!result.chunk_started && result.fetched_byte == '0)
		else $error("dropped byte reported with other activity");

endmodule

bind ring_buffer_dma_chunker_top rbdc_checker u_rbdc_checker (.*);

// File: tb/sv/chunker_checker.sv
`timescale 1ns / 1ps

module chunker_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  rbdc_pkg::rbdc_in_t  item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  rbdc_pkg::rbdc_out_t result,
	output int                  errors,
	output int                  pending,
	output logic [511:0]        written
);

	import rbdc_pkg::*;

	localparam int RING_DEPTH = 512;
	localparam int CHUNK_MAX  = 32;

	logic [7:0] ring_mem [RING_DEPTH];
	logic [8:0] wr_pos;
	logic [8:0] snd_pos;
	logic [5:0] in_flight;
	rbdc_out_t  ring_replies [$];

	function automatic rbdc_out_t ring_step(rbdc_in_t w);
		rbdc_out_t  r;
		logic [8:0] nxt;
		logic [8:0] aft;
		logic       try_chunk;
		int         stop;
		int         n;
		r = '0;
		try_chunk = 1'b0;
		case (w.command)
			CMD_PUSH: begin
				nxt = wr_pos + 9'd1;
				if (nxt == snd_pos) begin
					r.byte_dropped = 1'b1;
				end else begin
					ring_mem[wr_pos] = w.byte_value;
					written[wr_pos] = 1'b1;
					wr_pos = nxt;
					aft = nxt + 9'd1;
					// message end, wrap to zero, or ring just went full
					try_chunk = w.last_of_message || nxt == 9'd0 || aft == snd_pos;
				end
			end
			CMD_DONE: begin
				// retire the chunk; an advance that reaches the ring end snaps to 0
				if (int'(snd_pos) + int'(in_flight) >= RING_DEPTH)
					snd_pos = '0;
				else
					snd_pos = snd_pos + 9'(in_flight);
				in_flight = '0;
				try_chunk = 1'b1;
			end
			CMD_FETCH: begin
				r.fetched_byte = ring_mem[w.fetch_index];
			end
			default: ;
		endcase
		if (try_chunk && in_flight == '0 && wr_pos != snd_pos) begin
			// contiguous run only: stop at the ring end when the data wraps
			stop = (wr_pos <= snd_pos) ? RING_DEPTH : int'(wr_pos);
			n = stop - int'(snd_pos);
			if (n > CHUNK_MAX)
				n = CHUNK_MAX;
			in_flight = 6'(n);
			r.chunk_started = 1'b1;
			r.chunk_start_index = snd_pos;
			r.chunk_length = 6'(n);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		rbdc_out_t want;
		if (!arst_n) begin
			wr_pos = '0;
			snd_pos = '0;
			in_flight = '0;
			written = '0;
			ring_replies.delete();
		end else begin
			if (item_valid && item_ready)
				ring_replies.push_back(ring_step(item));
			if (result_valid && result_ready) begin
				if (ring_replies.size() == 0) begin
					if (errors < 10)
						$display("%0t: result word %h with nothing due", $realtime, result);
					errors++;
				end else begin
					want = ring_replies.pop_front();
					if (result !== want) begin
						if (errors < 10) begin
							$write("%0t: mismatch exp drop=%0d start=%0d idx=%0d len=%0d byte=%h",
								$realtime, want.byte_dropped, want.chunk_started,
								want.chunk_start_index, want.chunk_length, want.fetched_byte);
							$display(", got drop=%0d start=%0d idx=%0d len=%0d byte=%h",
								result.byte_dropped, result.chunk_started,
								result.chunk_start_index, result.chunk_length,
								result.fetched_byte);
						end
						errors++;
					end
				end
			end
		end
		pending = ring_replies.size();
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import rbdc_pkg::*;

	localparam int ITEM_COUNT  = 1800;
	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         item_valid = 1'b0;
	logic         item_ready;
	rbdc_in_t     item = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	rbdc_out_t    result;
	int           errors;
	int           pending;
	logic [511:0] written;
	int           sent = 0;
	int           send_idle_pct = 37;
	int           recv_idle_pct = 81;
	int           quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ring_buffer_dma_chunker_top dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result
	);

	chunker_checker chk (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result,
		.errors,
		.pending,
		.written
	);

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// counts cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic rbdc_in_t word_of(logic [1:0] cmd, logic [7:0] val, logic last,
			logic [8:0] idx);
		rbdc_in_t w;
		w.command = cmd;
		w.byte_value = val;
		w.last_of_message = last;
		w.fetch_index = idx;
		return w;
	endfunction

	task automatic send_word(input rbdc_in_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item <= w;
		item_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!item_ready);
		if (w.command == CMD_PUSH || w.command == CMD_DONE || w.command == CMD_FETCH)
			sent++;
		if (sent == ITEM_COUNT / 3) begin
			send_idle_pct = 81;
			recv_idle_pct = 37;
		end else if (sent == 2 * ITEM_COUNT / 3) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	task automatic push_byte(input logic [7:0] val, input logic last);
		send_word(word_of(CMD_PUSH, val, last, 9'($urandom)));
	endtask

	task automatic complete();
		send_word(word_of(CMD_DONE, 8'($urandom), 1'($urandom), 9'($urandom)));
	endtask

	task automatic fetch_at(input logic [8:0] idx);
		send_word(word_of(CMD_FETCH, 8'($urandom), 1'($urandom), idx));
	endtask

	// only entries that already hold a byte are read back
	task automatic fetch_any();
		int base;
		int idx;
		bit found;
		base = $urandom_range(511);
		found = 1'b0;
		idx = 0;
		for (int k = 0; k < 512 && !found; k++) begin
			idx = (base + k) % 512;
			found = written[idx];
		end
		if (found)
			fetch_at(9'(idx));
		else
			push_byte(8'($urandom), 1'b0);
	endtask

	initial begin
		int kind;
		int len;
		logic [1:0] cmd;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		complete();             // nothing in flight, ring empty
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);  // message end starts a chunk
		push_byte(8'hA5, 1'b1);  // chunk busy, no start
		fetch_at(9'd0);
		fetch_at(9'd1);
		fetch_at(9'd2);
		complete();
		send_word(word_of(CMD_UNUSED, 8'hFF, 1'b1, 9'h1FF));
		send_word(word_of(CMD_UNUSED, 8'h00, 1'b0, 9'h000));
		complete();
		complete();
		push_byte(8'h5A, 1'b0);
		push_byte(8'hC3, 1'b1);
		fetch_at(9'd3);
		complete();
		complete();

		// long fill: ring goes full, drops, and the write side wraps
		repeat (560) push_byte(8'($urandom), $urandom_range(31) == 0);

		while (sent < ITEM_COUNT) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				len = $urandom_range(1, 40);
				for (int k = 1; k <= len; k++) begin
					push_byte(8'($urandom), k == len);
					if ($urandom_range(5) == 0)
						fetch_any();
				end
			end else if (kind < 45) begin
				len = $urandom_range(40, 250);
				repeat (len) push_byte(8'($urandom), $urandom_range(31) == 0);
			end else if (kind < 70) begin
				repeat ($urandom_range(1, 10)) complete();
			end else if (kind < 85) begin
				repeat ($urandom_range(1, 6)) fetch_any();
			end else begin
				repeat ($urandom_range(1, 8)) begin
					cmd = 2'($urandom);
					if (cmd == CMD_FETCH)
						fetch_any();
					else
						send_word(word_of(cmd, 8'($urandom), 1'($urandom), 9'($urandom)));
				end
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (5) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
